// ===== sv/sbpn_pkg.sv =====
`default_nettype none

package sbpn_pkg;

  localparam int NUM_BANDS  = 32;
  localparam int POWER_BITS = 16;
  localparam int SUM_BITS   = 24;

  // Field widths of the channels
  localparam int POWER_W  = 16;
  localparam int LEVEL_W  = 16;
  localparam int NUMBER_W = 5;

  localparam int PWR_USE = (POWER_BITS < POWER_W) ? POWER_BITS : POWER_W;
  localparam int FILL_W  = $clog2(NUM_BANDS + 1);
  localparam int IDX_W   = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int CNT_W   = $clog2(LEVEL_W);

  localparam logic [FILL_W-1:0]  BANDS_FULL = FILL_W'(NUM_BANDS);
  localparam logic [LEVEL_W-1:0] LEVEL_MAX  = '1;

  localparam int STEP_W = 3;

  localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_STORE  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_READ   = 3'd2;
  localparam logic [STEP_W-1:0] STEP_LOAD   = 3'd3;
  localparam logic [STEP_W-1:0] STEP_DIV    = 3'd4;
  localparam logic [STEP_W-1:0] STEP_EMIT   = 3'd5;
  localparam logic [STEP_W-1:0] STEP_NEXT   = 3'd6;
  localparam logic [STEP_W-1:0] STEP_FINISH = 3'd7;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_CLOSE,
    COND_NO_FRAME,
    COND_DIV_MORE,
    COND_OUT_BUSY,
    COND_MORE_BANDS
  } cond_e;

  typedef struct packed {
    logic              in_ready;
    logic              store;
    logic              rd;
    logic              div_load;
    logic              div_step;
    logic              out_load;
    logic              next_band;
    logic              finish;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic close_acc;
    logic frame;
    logic div_more;
    logic out_busy;
    logic more_bands;
  } status_t;

  function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
    uword_t w;
    w        = '0;
    w.cond   = COND_NEVER;
    w.target = STEP_IDLE;
    unique case (step)
      STEP_IDLE: begin
        w.in_ready = 1'b1;
        w.cond     = COND_NO_CLOSE;
        w.target   = STEP_IDLE;
      end
      STEP_STORE: begin
        w.store  = 1'b1;
        w.cond   = COND_NO_FRAME;
        w.target = STEP_IDLE;
      end
      STEP_READ: begin
        w.rd = 1'b1;
      end
      STEP_LOAD: begin
        w.div_load = 1'b1;
      end
      STEP_DIV: begin
        w.div_step = 1'b1;
        w.cond     = COND_DIV_MORE;
        w.target   = STEP_DIV;
      end
      STEP_EMIT: begin
        w.out_load = 1'b1;
        w.cond     = COND_OUT_BUSY;
        w.target   = STEP_EMIT;
      end
      STEP_NEXT: begin
        w.next_band = 1'b1;
        w.cond      = COND_MORE_BANDS;
        w.target    = STEP_READ;
      end
      STEP_FINISH: begin
        w.finish = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== sv/sbpn_ifs.sv =====
`default_nettype none

interface sbpn_bin_if import sbpn_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [POWER_W-1:0] bin_power;
  logic               bin_present;
  logic               closes_band;
  logic               closes_frame;

  modport source (output valid, bin_power, bin_present, closes_band, closes_frame,
                  input ready);
  modport sink   (input valid, bin_power, bin_present, closes_band, closes_frame,
                  output ready);
endinterface

interface sbpn_band_if import sbpn_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LEVEL_W-1:0]  band_level;
  logic [NUMBER_W-1:0] band_number;
  logic                last_band;

  modport source (output valid, band_level, band_number, last_band, input ready);
  modport sink   (input valid, band_level, band_number, last_band, output ready);
endinterface

`default_nettype wire

// ===== sv/spectrum_band_peak_normalizer.sv =====
// A bin beat that does not close a band keeps the input open; a closing beat adds a store step.
// A frame close then emits each stored band through memory read, divider load,
// 16 steps of the shared one-bit-per-cycle divider, output load and index advance,
// plus a finishing step; output back-pressure stalls the sequence at the output load.
// Reset clears the sequencer step, running sum, maximum, fill count and output valid;
// the band store is not cleared and only entries written in the current frame are read.
`default_nettype none

module spectrum_band_peak_normalizer import sbpn_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  sbpn_bin_if.sink     bin_i,
  sbpn_band_if.source  band_o
);

  uword_t  ctrl;
  status_t status;

  sbpn_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  sbpn_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .in_valid_i     (bin_i.valid),
    .bin_power_i    (bin_i.bin_power),
    .bin_present_i  (bin_i.bin_present),
    .closes_band_i  (bin_i.closes_band),
    .closes_frame_i (bin_i.closes_frame),
    .out_ready_i    (band_o.ready),
    .status_o       (status),
    .out_valid_o    (band_o.valid),
    .band_level_o   (band_o.band_level),
    .band_number_o  (band_o.band_number),
    .last_band_o    (band_o.last_band)
  );

  assign bin_i.ready = ctrl.in_ready;

  a_close_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bin_i.valid && bin_i.ready && (bin_i.closes_band || bin_i.closes_frame))
      |=> !bin_i.ready)
    else $error("input taken in the cycle after a band close");

  a_plain_bin_streams: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bin_i.valid && bin_i.ready && !bin_i.closes_band && !bin_i.closes_frame)
      |=> bin_i.ready)
    else $error("plain bin beat did not keep the input open");

  a_one_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl.store, ctrl.rd, ctrl.div_load, ctrl.div_step,
              ctrl.out_load, ctrl.next_band, ctrl.finish}))
    else $error("control word drives more than one datapath action");

endmodule

`default_nettype wire

// ===== sv/sbpn_divider.sv =====
`default_nettype none

module sbpn_divider import sbpn_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                load_i,
  input  wire logic                step_i,
  input  wire logic [SUM_BITS-1:0] num_i,
  input  wire logic [SUM_BITS-1:0] den_i,
  output logic      [LEVEL_W-1:0]  quot_o,
  output logic                     more_o
);

  logic [SUM_BITS:0]  rem_q, rem_d, shifted;
  logic [LEVEL_W-1:0] quot_q, quot_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               ge;

  // One quotient bit per step, restoring
  always_comb begin
    shifted = {rem_q[SUM_BITS-1:0], 1'b0};
    ge      = shifted >= {1'b0, den_i};
    rem_d   = rem_q;
    quot_d  = quot_q;
    cnt_d   = cnt_q;
    if (load_i) begin
      rem_d  = {1'b0, num_i};
      quot_d = '0;
      cnt_d  = '0;
    end else if (step_i) begin
      rem_d  = ge ? (shifted - {1'b0, den_i}) : shifted;
      quot_d = {quot_q[LEVEL_W-2:0], ge};
      cnt_d  = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign quot_o = quot_q;
  assign more_o = cnt_q != CNT_W'(LEVEL_W - 1);

endmodule

`default_nettype wire

// ===== sv/sbpn_datapath.sv =====
`default_nettype none

module sbpn_datapath import sbpn_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire uword_t              ctrl_i,
  input  wire logic                in_valid_i,
  input  wire logic [POWER_W-1:0]  bin_power_i,
  input  wire logic                bin_present_i,
  input  wire logic                closes_band_i,
  input  wire logic                closes_frame_i,
  input  wire logic                out_ready_i,
  output status_t                  status_o,
  output logic                     out_valid_o,
  output logic      [LEVEL_W-1:0]  band_level_o,
  output logic      [NUMBER_W-1:0] band_number_o,
  output logic                     last_band_o
);

  logic [SUM_BITS-1:0] band_mem [NUM_BANDS];
  logic [SUM_BITS-1:0] rd_data_q;

  logic [SUM_BITS-1:0] running_q, running_d;
  logic [SUM_BITS-1:0] largest_q, largest_d;
  logic [FILL_W-1:0]   filled_q, filled_d;
  logic [FILL_W-1:0]   idx_q, idx_d, idx_inc;
  logic                frame_q, frame_d;
  logic                out_valid_q, out_valid_d;
  logic [LEVEL_W-1:0]  level_q;
  logic [NUMBER_W-1:0] number_q;
  logic                last_q;
  logic                sat_q, zero_q;

  logic                accept, out_busy, out_fire, room;
  logic [SUM_BITS:0]   sum_ext;
  logic [LEVEL_W-1:0]  quot;
  logic                div_more;

  sbpn_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (ctrl_i.div_load),
    .step_i (ctrl_i.div_step),
    .num_i  (rd_data_q),
    .den_i  (largest_q),
    .quot_o (quot),
    .more_o (div_more)
  );

  assign accept   = in_valid_i && ctrl_i.in_ready;
  assign room     = filled_q < BANDS_FULL;
  assign out_busy = out_valid_q && !out_ready_i;
  assign out_fire = ctrl_i.out_load && !out_busy;
  assign idx_inc  = idx_q + FILL_W'(1);
  assign sum_ext  = {1'b0, running_q} + (SUM_BITS + 1)'(bin_power_i[PWR_USE-1:0]);

  always_comb begin
    running_d   = running_q;
    largest_d   = largest_q;
    filled_d    = filled_q;
    idx_d       = idx_q;
    frame_d     = frame_q;
    out_valid_d = out_valid_q;

    if (accept) begin
      frame_d = closes_frame_i;
      if (bin_present_i) begin
        // saturate the band sum
        running_d = sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
      end
    end
    if (ctrl_i.store) begin
      running_d = '0;
      if (room) begin
        filled_d = filled_q + FILL_W'(1);
        if (running_q > largest_q) begin
          largest_d = running_q;
        end
      end
    end
    if (ctrl_i.next_band) begin
      idx_d = idx_inc;
    end
    if (ctrl_i.finish) begin
      filled_d  = '0;
      largest_d = '0;
      idx_d     = '0;
    end
    if (out_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q   <= '0;
      largest_q   <= '0;
      filled_q    <= '0;
      idx_q       <= '0;
      frame_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      running_q   <= running_d;
      largest_q   <= largest_d;
      filled_q    <= filled_d;
      idx_q       <= idx_d;
      frame_q     <= frame_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.store && room) begin
      band_mem[filled_q[IDX_W-1:0]] <= running_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      rd_data_q <= band_mem[idx_q[IDX_W-1:0]];
    end
  end

  // Flag the cases the divider does not cover
  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_load) begin
      zero_q <= largest_q == '0;
      sat_q  <= rd_data_q >= largest_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      level_q  <= zero_q ? '0 : (sat_q ? LEVEL_MAX : quot);
      number_q <= NUMBER_W'(idx_q);
      last_q   <= idx_inc == filled_q;
    end
  end

  always_comb begin
    status_o            = '0;
    status_o.close_acc  = accept && (closes_band_i || closes_frame_i);
    status_o.frame      = frame_q;
    status_o.div_more   = div_more;
    status_o.out_busy   = out_busy;
    status_o.more_bands = idx_inc != filled_q;
  end

  assign out_valid_o   = out_valid_q;
  assign band_level_o  = level_q;
  assign band_number_o = number_q;
  assign last_band_o   = last_q;

endmodule

`default_nettype wire

// ===== sv/sbpn_sequencer.sv =====
`default_nettype none

module sbpn_sequencer import sbpn_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire status_t status_i,
  output uword_t       ctrl_o
);

  logic [STEP_W-1:0] step_q, step_d;
  uword_t            word;
  logic              take;

  assign word   = ucode_rom(step_q);
  assign ctrl_o = word;

  always_comb begin
    case (word.cond)
      COND_NEVER:      take = 1'b0;
      COND_ALWAYS:     take = 1'b1;
      COND_NO_CLOSE:   take = !status_i.close_acc;
      COND_NO_FRAME:   take = !status_i.frame;
      COND_DIV_MORE:   take = status_i.div_more;
      COND_OUT_BUSY:   take = status_i.out_busy;
      COND_MORE_BANDS: take = status_i.more_bands;
      default:         take = 1'b0;
    endcase
    step_d = take ? word.target : step_q + STEP_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire
